>>> rtl/core/snp_pkg.sv
package snp_pkg;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_X_LO  = 8'h78;
	localparam logic [7:0] CH_X_UP  = 8'h58;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A_LO  = 8'h61;
	localparam logic [7:0] CH_F_LO  = 8'h66;
	localparam logic [7:0] CH_A_UP  = 8'h41;
	localparam logic [7:0] CH_F_UP  = 8'h46;

	localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// character class as seen by the back end
	typedef struct packed {
		logic       is_minus;
		logic       is_zero;
		logic       is_x;
		logic       dec_ok;
		logic       hex_ok;
		logic [3:0] digit;
		logic       last;
	} snp_item_t;

endpackage

>>> rtl/core/signed_number_text_parser.sv
// channel   direction  handshake                 payload
// char      in         char_valid / char_stall    character[7:0], last
// value     out        value_valid / value_stall  value[31:0] signed
//
// one character per cycle sustained, unless value_stall holds back a word end and the queue fills;
// a word's last character is written to the queue, then the output register loads as that character pops
// a two-entry queue sits between the classifier and the execute stage
// arst_n clears the queue, the word state and the output valid flag, but not the value register
// value_stall holds only characters marked last; others keep draining into the accumulator
module signed_number_text_parser #(
	parameter int unsigned CELL_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_stall,
	input  logic [7:0]         character,
	input  logic               last,
	output logic               value_valid,
	input  logic               value_stall,
	output logic signed [31:0] value
);
	import snp_pkg::*;

	snp_item_t cls_item;
	snp_item_t head_item;
	logic      q_full;
	logic      q_avail;
	logic      q_pop;

	snp_classify u_classify (
		.character (character),
		.last      (last),
		.item      (cls_item)
	);

	snp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (char_valid),
		.push_item (cls_item),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_avail),
		.head      (head_item)
	);

	snp_execute #(
		.CELL_WIDTH (CELL_WIDTH)
	) u_execute (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_avail  (q_avail),
		.item        (head_item),
		.item_pop    (q_pop),
		.value_valid (value_valid),
		.value_stall (value_stall),
		.value       (value)
	);

	assign char_stall = q_full;

endmodule

>>> rtl/core/snp_classify.sv
module snp_classify (
	input  logic              [7:0] character,
	input  logic                    last,
	output snp_pkg::snp_item_t      item
);
	import snp_pkg::*;

	logic is_dec;
	logic is_lo;
	logic is_up;

	always_comb begin
		is_dec = (character >= CH_0) && (character <= CH_9);
		is_lo  = (character >= CH_A_LO) && (character <= CH_F_LO);
		is_up  = (character >= CH_A_UP) && (character <= CH_F_UP);

		item.is_minus = (character == CH_MINUS);
		item.is_zero  = (character == CH_0);
		item.is_x     = (character == CH_X_LO) || (character == CH_X_UP);
		item.dec_ok   = is_dec;
		item.hex_ok   = is_dec || is_lo || is_up;
		item.last     = last;
		if (is_lo) begin
			item.digit = 4'(character - CH_A_LO) + HEX_LETTER_BASE;
		end else if (is_up) begin
			item.digit = 4'(character - CH_A_UP) + HEX_LETTER_BASE;
		end else begin
			item.digit = 4'(character - CH_0);
		end
	end

endmodule

>>> rtl/core/snp_queue.sv
module snp_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  snp_pkg::snp_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output snp_pkg::snp_item_t head
);
	import snp_pkg::*;

	snp_item_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/snp_execute.sv
module snp_execute #(
	parameter int unsigned CELL_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_avail,
	input  snp_pkg::snp_item_t item,
	output logic               item_pop,
	output logic               value_valid,
	input  logic               value_stall,
	output logic signed [31:0] value
);
	import snp_pkg::*;

	typedef enum logic [4:0] {
		PH_START      = 5'b00001,
		PH_AFTER_SIGN = 5'b00010,
		PH_AFTER_ZERO = 5'b00100,
		PH_DEC        = 5'b01000,
		PH_HEX        = 5'b10000
	} phase_t;

	phase_t                  phase_q, phase_d;
	logic                    neg_q, neg_d;
	logic                    halted_q, halted_d;
	logic [CELL_WIDTH-1:0]   acc_q, acc_d;
	logic [CELL_WIDTH-1:0]   acc_dec;
	logic [CELL_WIDTH-1:0]   acc_hex;
	logic signed [CELL_WIDTH-1:0] result;
	logic                    out_valid_q;
	logic signed [31:0]      value_q;

	// a word end needs the output register free, other characters never wait
	assign item_pop = item_avail && (!item.last || !out_valid_q || !value_stall);

	assign acc_dec = (acc_q << 3) + (acc_q << 1) + CELL_WIDTH'(item.digit);
	assign acc_hex = (acc_q << 4) | CELL_WIDTH'(item.digit);

	always_comb begin
		phase_d  = phase_q;
		neg_d    = neg_q;
		halted_d = halted_q;
		acc_d    = acc_q;
		if (!halted_q) begin
			case (phase_q)
				PH_START: begin
					if (item.is_minus) begin
						neg_d   = 1'b1;
						phase_d = PH_AFTER_SIGN;
					end else if (item.is_zero) begin
						phase_d = PH_AFTER_ZERO;
					end else if (item.dec_ok) begin
						acc_d   = acc_dec;
						phase_d = PH_DEC;
					end else begin
						halted_d = 1'b1;
					end
				end
				PH_AFTER_SIGN: begin
					if (item.is_zero) begin
						phase_d = PH_AFTER_ZERO;
					end else if (item.dec_ok) begin
						acc_d   = acc_dec;
						phase_d = PH_DEC;
					end else begin
						halted_d = 1'b1;
					end
				end
				PH_AFTER_ZERO: begin
					if (item.is_x) begin
						phase_d = PH_HEX;
					end else if (item.dec_ok) begin
						acc_d   = acc_dec;
						phase_d = PH_DEC;
					end else begin
						halted_d = 1'b1;
					end
				end
				PH_HEX: begin
					if (item.hex_ok) begin
						acc_d = acc_hex;
					end else begin
						halted_d = 1'b1;
					end
				end
				default: begin
					if (item.dec_ok) begin
						acc_d   = acc_dec;
						phase_d = PH_DEC;
					end else begin
						halted_d = 1'b1;
					end
				end
			endcase
		end
		result = neg_d ? signed'(-acc_d) : signed'(acc_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			neg_q       <= 1'b0;
			halted_q    <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !value_stall) begin
				out_valid_q <= 1'b0;
			end
			if (item_pop) begin
				if (item.last) begin
					phase_q     <= PH_START;
					neg_q       <= 1'b0;
					halted_q    <= 1'b0;
					acc_q       <= '0;
					out_valid_q <= 1'b1;
				end else begin
					phase_q  <= phase_d;
					neg_q    <= neg_d;
					halted_q <= halted_d;
					acc_q    <= acc_d;
				end
			end
		end
	end

	// sign-extend or cut the cell to the 32-bit result
	always_ff @(posedge clk) begin
		if (item_pop && item.last) begin
			value_q <= 32'(result);
		end
	end

	assign value_valid = out_valid_q;
	assign value       = value_q;

endmodule
